FILE: design/prrl_pkg.sv
// Shared types and constants for the process region range lookup block.
// Used by the top level, the region store and the port checker; depends on nothing.
package prrl_pkg;

    localparam int unsigned MAX_PROCESSES_DEF = 8;
    localparam int unsigned MAX_REGIONS_DEF   = 32;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned PID_W    = 23;
    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned PERM_W   = 3;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MD_REGISTER = 2'd0,
        MD_ADD      = 2'd1,
        MD_LOOKUP   = 2'd2,
        MD_CLEAR    = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_UNKNOWN  = 2'd1,
        ST_NOREGION = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PSRCH,
        S_RSRCH
    } t_state;

    // One stored region, without its owner tag.
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] limit;
        logic [PERM_W-1:0] perms;
        logic [ADDR_W-1:0] offset;
    } t_region;

endpackage

FILE: design/prrl_region_store.sv
// Region table memory: one write port, one registered read port.
// Depends on prrl_pkg for the region record type.
module prrl_region_store #(
    parameter int unsigned DEPTH   = prrl_pkg::MAX_REGIONS_DEF,
    parameter int unsigned OWNER_W = 3,
    parameter int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IDX_W-1:0]    i_waddr,
    input  prrl_pkg::t_region   i_wdata,
    input  logic [OWNER_W-1:0]  i_wowner,
    input  logic [IDX_W-1:0]    i_raddr,
    output prrl_pkg::t_region   o_rdata,
    output logic [OWNER_W-1:0]  o_rowner
);

    prrl_pkg::t_region  r_mem   [DEPTH];
    logic [OWNER_W-1:0] r_owner [DEPTH];
    prrl_pkg::t_region  r_rdata;
    logic [OWNER_W-1:0] r_rowner;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr]   <= i_wdata;
            r_owner[i_waddr] <= i_wowner;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata  <= r_mem[i_raddr];
        r_rowner <= r_owner[i_raddr];
    end

    assign o_rdata  = r_rdata;
    assign o_rowner = r_rowner;

endmodule

FILE: design/process_region_range_lookup.sv
// Top level of the process region range lookup: sequencer, process id table,
// compare logic. Depends on prrl_pkg and prrl_region_store.
//
//  channel   | direction | handshake                 | beat fields
//  ----------+-----------+---------------------------+---------------------------------
//  command   | in        | start high, busy low      | i_mode i_process_id i_address
//            |           |                           | i_limit_address i_permissions
//            |           |                           | i_file_offset
//  result    | out       | o_done strobe, one cycle  | o_status o_hit_start o_hit_end
//            |           |                           | o_hit_permissions o_hit_offset
//
// Timing: a clear's result strobe comes in the cycle after its accept, and busy
// never rises for it. Register and add walk the process id table one entry a cycle
// through its registered read port. A lookup then walks the region table the same
// way, one entry a cycle through the region store read port. The result strobe
// comes in the cycle busy falls, and a new command may be accepted in that same
// cycle.
// Reset: synchronous, active low; empties both tables (counts only) and idles.
// Stalls: the receiver cannot stall; each result is shown for exactly one cycle.
module process_region_range_lookup #(
    parameter int unsigned MAX_PROCESSES = prrl_pkg::MAX_PROCESSES_DEF,
    parameter int unsigned MAX_REGIONS   = prrl_pkg::MAX_REGIONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [prrl_pkg::MODE_W-1:0]    i_mode,
    input  logic [prrl_pkg::PID_W-1:0]     i_process_id,
    input  logic [prrl_pkg::ADDR_W-1:0]    i_address,
    input  logic [prrl_pkg::ADDR_W-1:0]    i_limit_address,
    input  logic [prrl_pkg::PERM_W-1:0]    i_permissions,
    input  logic [prrl_pkg::ADDR_W-1:0]    i_file_offset,
    output logic                           o_done,
    output logic [prrl_pkg::STATUS_W-1:0]  o_status,
    output logic [prrl_pkg::ADDR_W-1:0]    o_hit_start,
    output logic [prrl_pkg::ADDR_W-1:0]    o_hit_end,
    output logic [prrl_pkg::PERM_W-1:0]    o_hit_permissions,
    output logic [prrl_pkg::ADDR_W-1:0]    o_hit_offset
);

    // Index widths address the tables; count widths can also hold the depth.
    localparam int unsigned PID_IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int unsigned PCNT_W = $clog2(MAX_PROCESSES + 1);
    localparam int unsigned REG_IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned RCNT_W = $clog2(MAX_REGIONS + 1);

    localparam logic [PCNT_W-1:0] PCNT_FULL = PCNT_W'(MAX_PROCESSES);
    localparam logic [RCNT_W-1:0] RCNT_FULL = RCNT_W'(MAX_REGIONS);

    logic accept;

    prrl_pkg::t_state r_state, n_state;

    // Latched command payload.
    prrl_pkg::t_mode            r_mode;
    logic [prrl_pkg::PID_W-1:0] r_pid;
    prrl_pkg::t_region          r_cmd;

    // Table fill counts.
    logic [PCNT_W-1:0] r_pcount, n_pcount;
    logic [RCNT_W-1:0] r_rcount, n_rcount;

    // Process id walk: issue index, read-in-flight flag, index under compare.
    logic [PCNT_W-1:0] r_pidx, n_pidx;
    logic              r_pv, n_pv;
    logic [PID_IW-1:0] r_pcmp_idx, n_pcmp_idx;
    logic [PID_IW-1:0] r_slot, n_slot;

    // Region walk.
    logic [RCNT_W-1:0] r_ridx, n_ridx;
    logic              r_rv, n_rv;

    // Result register.
    logic                       r_done, n_done;
    prrl_pkg::t_status          r_status, n_status;
    prrl_pkg::t_region          r_hit, n_hit;

    // Process id memory.
    logic [prrl_pkg::PID_W-1:0] r_pid_mem [MAX_PROCESSES];
    logic [prrl_pkg::PID_W-1:0] r_pid_rdata;
    logic                       pid_we;

    // Region store ports.
    logic                       reg_we;
    prrl_pkg::t_region          reg_rdata;
    logic [PID_IW-1:0]          reg_rowner;

    // Compare results for the process id walk and the region walk.
    logic pid_match, pid_miss_all, reg_match, reg_miss_all;
    logic pid_issue, reg_issue;

    assign accept = start && (r_state == prrl_pkg::S_IDLE);
    assign busy   = (r_state != prrl_pkg::S_IDLE);

    assign pid_issue    = (r_pidx < r_pcount);
    assign pid_match    = r_pv && (r_pid_rdata == r_pid);
    assign pid_miss_all = !pid_match && !pid_issue;

    assign reg_issue    = (r_ridx < r_rcount);
    assign reg_match    = r_rv && (reg_rowner == r_slot)
                          && (r_cmd.start >= reg_rdata.start)
                          && (r_cmd.start < reg_rdata.limit);
    assign reg_miss_all = !reg_match && !reg_issue;

    // Process id memory: write the new id at the fill count, read at the walk index.
    always_ff @(posedge i_clk) begin
        if (pid_we) begin
            r_pid_mem[r_pcount[PID_IW-1:0]] <= r_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid_rdata <= r_pid_mem[r_pidx[PID_IW-1:0]];
    end

    prrl_region_store #(
        .DEPTH   (MAX_REGIONS),
        .OWNER_W (PID_IW),
        .IDX_W   (REG_IW)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (reg_we),
        .i_waddr  (r_rcount[REG_IW-1:0]),
        .i_wdata  (r_cmd),
        .i_wowner (r_pcmp_idx),
        .i_raddr  (r_ridx[REG_IW-1:0]),
        .o_rdata  (reg_rdata),
        .o_rowner (reg_rowner)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            prrl_pkg::S_IDLE: begin
                if (accept) begin
                    if (prrl_pkg::t_mode'(i_mode) == prrl_pkg::MD_CLEAR) begin
                        n_state = prrl_pkg::S_IDLE;
                    end else begin
                        n_state = prrl_pkg::S_PSRCH;
                    end
                end
            end
            prrl_pkg::S_PSRCH: begin
                if (pid_match) begin
                    if (r_mode == prrl_pkg::MD_LOOKUP) begin
                        n_state = prrl_pkg::S_RSRCH;
                    end else begin
                        n_state = prrl_pkg::S_IDLE;
                    end
                end else if (pid_miss_all) begin
                    n_state = prrl_pkg::S_IDLE;
                end
            end
            prrl_pkg::S_RSRCH: begin
                if (reg_match || reg_miss_all) begin
                    n_state = prrl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = prrl_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath controls and result.
    always_comb begin
        n_pcount   = r_pcount;
        n_rcount   = r_rcount;
        n_pidx     = r_pidx;
        n_pv       = 1'b0;
        n_pcmp_idx = r_pcmp_idx;
        n_slot     = r_slot;
        n_ridx     = r_ridx;
        n_rv       = 1'b0;
        n_done     = 1'b0;
        n_status   = prrl_pkg::ST_OK;
        n_hit      = '0;
        pid_we     = 1'b0;
        reg_we     = 1'b0;
        case (r_state)
            prrl_pkg::S_IDLE: begin
                if (accept) begin
                    n_pidx = '0;
                    if (prrl_pkg::t_mode'(i_mode) == prrl_pkg::MD_CLEAR) begin
                        // Drop both tables by zeroing the counts.
                        n_pcount = '0;
                        n_rcount = '0;
                        n_done   = 1'b1;
                    end
                end
            end
            prrl_pkg::S_PSRCH: begin
                // Advance the walk; one id is compared each cycle.
                n_pv       = pid_issue && !pid_match;
                n_pidx     = pid_issue ? (r_pidx + PCNT_W'(1)) : r_pidx;
                n_pcmp_idx = r_pidx[PID_IW-1:0];
                if (pid_match) begin
                    n_slot = r_pcmp_idx;
                    case (r_mode)
                        prrl_pkg::MD_REGISTER: begin
                            n_done = 1'b1;
                        end
                        prrl_pkg::MD_ADD: begin
                            n_done = 1'b1;
                            if (r_rcount >= RCNT_FULL) begin
                                n_status = prrl_pkg::ST_FULL;
                            end else begin
                                reg_we   = 1'b1;
                                n_rcount = r_rcount + RCNT_W'(1);
                            end
                        end
                        prrl_pkg::MD_LOOKUP: begin
                            n_ridx = '0;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end else if (pid_miss_all) begin
                    n_done = 1'b1;
                    if (r_mode == prrl_pkg::MD_REGISTER) begin
                        if (r_pcount >= PCNT_FULL) begin
                            n_status = prrl_pkg::ST_FULL;
                        end else begin
                            pid_we   = 1'b1;
                            n_pcount = r_pcount + PCNT_W'(1);
                        end
                    end else begin
                        n_status = prrl_pkg::ST_UNKNOWN;
                    end
                end
            end
            prrl_pkg::S_RSRCH: begin
                n_rv   = reg_issue && !reg_match;
                n_ridx = reg_issue ? (r_ridx + RCNT_W'(1)) : r_ridx;
                if (reg_match) begin
                    n_done = 1'b1;
                    n_hit  = reg_rdata;
                end else if (reg_miss_all) begin
                    n_done   = 1'b1;
                    n_status = prrl_pkg::ST_NOREGION;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= prrl_pkg::S_IDLE;
            r_pcount <= '0;
            r_rcount <= '0;
            r_pidx   <= '0;
            r_pv     <= 1'b0;
            r_ridx   <= '0;
            r_rv     <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pcount <= n_pcount;
            r_rcount <= n_rcount;
            r_pidx   <= n_pidx;
            r_pv     <= n_pv;
            r_ridx   <= n_ridx;
            r_rv     <= n_rv;
            r_done   <= n_done;
        end
    end

    // Payload registers hold the command for the whole walk; the rest load every cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode       <= prrl_pkg::t_mode'(i_mode);
            r_pid        <= i_process_id;
            r_cmd.start  <= i_address;
            r_cmd.limit  <= i_limit_address;
            r_cmd.perms  <= i_permissions;
            r_cmd.offset <= i_file_offset;
        end
        r_pcmp_idx <= n_pcmp_idx;
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_hit      <= n_hit;
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_hit_start       = r_hit.start;
    assign o_hit_end         = r_hit.limit;
    assign o_hit_permissions = r_hit.perms;
    assign o_hit_offset      = r_hit.offset;

endmodule

FILE: design/prrl_checker.sv
// Port-level checker for process_region_range_lookup, bound to the top level.
// Depends on prrl_pkg for the status codes and port widths.
module prrl_port_props (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_done,
    input logic [prrl_pkg::STATUS_W-1:0]  o_status,
    input logic [prrl_pkg::ADDR_W-1:0]    o_hit_start,
    input logic [prrl_pkg::ADDR_W-1:0]    o_hit_end,
    input logic [prrl_pkg::PERM_W-1:0]    o_hit_permissions,
    input logic [prrl_pkg::ADDR_W-1:0]    o_hit_offset
);

    // An accepted beat either keeps the block busy or finishes at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted beat neither busy nor done");

    // A result arrives only when the block is free to take the next beat.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Busy rises only on an accept.
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted beat");

    // A result follows work in progress or an accept.
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result strobe without a command");

    // Hit fields are zero on any result whose status is not OK.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != prrl_pkg::ST_OK)) |->
        ((o_hit_start == '0) && (o_hit_end == '0) && (o_hit_permissions == '0)
         && (o_hit_offset == '0)))
        else $error("hit fields nonzero on a miss");

endmodule

bind process_region_range_lookup prrl_port_props u_prrl_port_props (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_status          (o_status),
    .o_hit_start       (o_hit_start),
    .o_hit_end         (o_hit_end),
    .o_hit_permissions (o_hit_permissions),
    .o_hit_offset      (o_hit_offset)
);
